/* sv/pctab_pkg.sv */
// ----------------------------------------------------------------------------
// Parameter change-point table package
// Shared types, widths and codes for the change-point table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pctab_pkg;

    localparam int MAX_QUEUES_DEF = 32;
    localparam int MAX_POINTS_DEF = 16;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 11;
    localparam int USED_W = 9;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_ADD       = 3'd1;
    localparam logic [2:0] CMD_SET       = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_READ_LAST = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        param_id;
        logic signed [31:0] sample_offset;
        logic [63:0]        point_value;
        logic [4:0]         entry_select;
        logic [3:0]         point_select;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         queue_index;
        logic [3:0]         point_index;
        logic [31:0]        found_id;
        logic signed [31:0] found_offset;
        logic [63:0]        found_value;
        logic [4:0]         point_count;
        logic [5:0]         queues_in_use;
    } t_out;

    typedef struct packed {
        logic signed [31:0] offset;
        logic [63:0]        value;
    } t_point;

    typedef struct packed {
        logic              load_pick;
        logic              mode_read;
        logic [31:0]       key;
        logic [IDX_W-1:0]  esel;
        logic [USED_W-1:0] used;
        logic              we_id;
        logic              we_cnt;
        logic [IDX_W-1:0]  widx;
        logic [31:0]       wid;
        logic [CNT_W-1:0]  wcnt;
    } t_cell_ctl;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      id;
        logic [CNT_W-1:0] cnt;
    } t_chain;

endpackage

`default_nettype wire

/* sv/pctab_cell.sv */
// ----------------------------------------------------------------------------
// Change-point table cell
// Holds one entry's identifier and point count and passes the first match on.
// ----------------------------------------------------------------------------
`default_nettype none

module pctab_cell #(
    parameter int IDX = 0
) (
    input  wire                  i_clk,
    input  pctab_pkg::t_cell_ctl i_ctl,
    input  pctab_pkg::t_chain    i_chain,
    output pctab_pkg::t_chain    o_chain
);

    localparam logic [pctab_pkg::IDX_W-1:0]  MY_IDX  = pctab_pkg::IDX_W'(IDX);
    localparam logic [pctab_pkg::USED_W-1:0] MY_USED = pctab_pkg::USED_W'(IDX);

    logic [31:0]                 r_id;
    logic [pctab_pkg::CNT_W-1:0] r_cnt;
    logic                        r_pick;
    logic                        n_pick;

    always_comb begin
        if (i_ctl.mode_read) begin
            n_pick = (i_ctl.esel == MY_IDX) && (MY_USED < i_ctl.used);
        end else begin
            n_pick = (r_id == i_ctl.key) && (MY_USED < i_ctl.used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pick) begin
            r_pick <= n_pick;
        end
        if (i_ctl.we_id && i_ctl.widx == MY_IDX) begin
            r_id <= i_ctl.wid;
        end
        if (i_ctl.we_cnt && i_ctl.widx == MY_IDX) begin
            r_cnt <= i_ctl.wcnt;
        end
    end

    always_comb begin
        if (!i_chain.found && r_pick) begin
            o_chain.found = 1'b1;
            o_chain.idx   = MY_IDX;
            o_chain.id    = r_id;
            o_chain.cnt   = r_cnt;
        end else begin
            o_chain = i_chain;
        end
    end

endmodule

`default_nettype wire

/* sv/parameter_change_point_table.sv */
// ----------------------------------------------------------------------------
// Parameter change-point table
// Table of parameter entries, each with a bounded list of offset/value points.
// ----------------------------------------------------------------------------
// A request is accepted in idle. Every entry cell then compares its identifier,
// or its index on a read, and registers whether it is picked. The first match
// then ripples down the cell row and the point memory is written or addressed;
// a read that returns a point adds the registered point memory read before the
// result is presented to be taken. A new request is accepted once the previous
// result has been taken, so a stalled result holds the input off.
`default_nettype none

module parameter_change_point_table #(
    parameter int MAX_QUEUES = pctab_pkg::MAX_QUEUES_DEF,
    parameter int MAX_POINTS = pctab_pkg::MAX_POINTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  pctab_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output pctab_pkg::t_out   o_out_data,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [2:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DEPTH = MAX_QUEUES * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = pctab_pkg::IDX_W;
    localparam int CW    = pctab_pkg::CNT_W;
    localparam int UW    = pctab_pkg::USED_W;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_READ} t_state;

    t_state             r_state;
    pctab_pkg::t_in     r_req;
    pctab_pkg::t_out    r_out;
    logic               r_out_valid;
    logic [UW-1:0]      r_used;
    logic [5:0]         r_qlim;
    logic [4:0]         r_plim;
    pctab_pkg::t_point  r_rdata;
    pctab_pkg::t_point  r_mem [DEPTH];

    pctab_pkg::t_cell_ctl ctl;
    pctab_pkg::t_chain    chain [MAX_QUEUES+1];
    pctab_pkg::t_chain    ch;

    logic              accept;
    logic              is_rw_read;
    logic              is_write_cmd;
    logic [CW-1:0]     pl1;
    logic [CW-1:0]     pcap;
    logic [UW-1:0]     qcap;
    logic              full;
    logic [IW-1:0]     e;
    logic [CW-1:0]     old_cnt;
    logic [CW-1:0]     p;
    logic [CW-1:0]     new_cnt;
    logic              rd_ok;
    logic [CW-1:0]     rp;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              mem_we;
    pctab_pkg::t_out   n_out;
    logic              n_read;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = !(r_state == S_IDLE && !r_out_valid);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? {27'd0, r_plim} : {26'd0, r_qlim};

    assign is_rw_read   = (r_req.command == pctab_pkg::CMD_READ)
                       || (r_req.command == pctab_pkg::CMD_READ_LAST);
    assign is_write_cmd = (r_req.command == pctab_pkg::CMD_ADD)
                       || (r_req.command == pctab_pkg::CMD_SET);

    assign chain[0] = '0;
    assign ch       = chain[MAX_QUEUES];

    genvar g;
    generate
        for (g = 0; g < MAX_QUEUES; g++) begin : g_cell
            pctab_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_chain (chain[g]),
                .o_chain (chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        pl1  = (r_plim == 5'd0) ? CW'(1) : CW'(r_plim);
        pcap = (pl1 > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pl1;
        qcap = (UW'(r_qlim) > UW'(MAX_QUEUES)) ? UW'(MAX_QUEUES) : UW'(r_qlim);
        full = !ch.found && (r_used >= qcap);
        e       = ch.found ? ch.idx : IW'(r_used);
        old_cnt = ch.found ? ch.cnt : '0;
        if (r_req.command == pctab_pkg::CMD_SET) begin
            p       = '0;
            new_cnt = CW'(1);
        end else if (old_cnt < pcap) begin
            p       = old_cnt;
            new_cnt = old_cnt + CW'(1);
        end else begin
            p       = pcap - CW'(1);
            new_cnt = pcap;
        end
        if (r_req.command == pctab_pkg::CMD_READ) begin
            rp    = CW'(r_req.point_select);
            rd_ok = rp < ch.cnt;
        end else begin
            rd_ok = ch.cnt != '0;
            rp    = rd_ok ? ch.cnt - CW'(1) : '0;
        end
        waddr  = AW'(32'(e) * 32'(MAX_POINTS) + 32'(p));
        raddr  = AW'(32'(ch.idx) * 32'(MAX_POINTS) + 32'(rp));
        mem_we = (r_state == S_EXEC) && is_write_cmd && !full;

        ctl.load_pick = (r_state == S_LOOK);
        ctl.mode_read = is_rw_read;
        ctl.key       = r_req.param_id;
        ctl.esel      = IW'(r_req.entry_select);
        ctl.used      = r_used;
        ctl.we_id     = mem_we && !ch.found;
        ctl.we_cnt    = mem_we;
        ctl.widx      = e;
        ctl.wid       = r_req.param_id;
        ctl.wcnt      = new_cnt;
    end

    always_comb begin
        n_out  = '0;
        n_read = 1'b0;
        if (is_write_cmd) begin
            if (full) begin
                n_out.status        = pctab_pkg::ST_FULL;
                n_out.queues_in_use = 6'(r_used);
            end else begin
                n_out.status        = pctab_pkg::ST_OK;
                n_out.queue_index   = 5'(e);
                n_out.point_index   = 4'(p);
                n_out.found_id      = ch.found ? ch.id : r_req.param_id;
                n_out.found_offset  = r_req.sample_offset;
                n_out.found_value   = r_req.point_value;
                n_out.point_count   = 5'(new_cnt);
                n_out.queues_in_use = ch.found ? 6'(r_used) : 6'(r_used + UW'(1));
            end
        end else if (is_rw_read) begin
            n_out.queues_in_use = 6'(r_used);
            if (!ch.found) begin
                n_out.status = pctab_pkg::ST_RANGE;
            end else begin
                n_out.queue_index = 5'(ch.idx);
                n_out.found_id    = ch.id;
                n_out.point_count = 5'(ch.cnt);
                n_out.point_index = 4'(rp);
                if (rd_ok) begin
                    n_out.status = pctab_pkg::ST_OK;
                    n_read       = 1'b1;
                end else begin
                    n_out.status = pctab_pkg::ST_RANGE;
                end
            end
        end else if (r_req.command != pctab_pkg::CMD_CLEAR) begin
            n_out.status        = pctab_pkg::ST_RANGE;
            n_out.queues_in_use = 6'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= {r_req.sample_offset, r_req.point_value};
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_qlim      <= 6'd32;
            r_plim      <= 5'd16;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2]) begin
                    r_plim <= pwdata[4:0];
                end else begin
                    r_qlim <= pwdata[5:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_in_data;
                        r_state <= S_LOOK;
                    end else if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_LOOK: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_out       <= n_out;
                    r_out_valid <= !n_read;
                    r_state     <= n_read ? S_READ : S_IDLE;
                    if (r_req.command == pctab_pkg::CMD_CLEAR) begin
                        r_used <= '0;
                    end else if (is_write_cmd && !full && !ch.found) begin
                        r_used <= r_used + UW'(1);
                    end
                end
                S_READ: begin
                    r_out.found_offset <= r_rdata.offset;
                    r_out.found_value  <= r_rdata.value;
                    r_out_valid        <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_LOOK)
        else $error("accepted request did not start a lookup");
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_QUEUES))
        else $error("entry count beyond table size");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

/* sim/tb_parameter_change_point_table.sv */
// ----------------------------------------------------------------------------
// Parameter change-point table testbench
// Drives a table of directed requests and then random requests, with
// scoreboarding against an in-bench model of the table (or fixed results for
// some directed rows). Table limits are written over the configuration port
// between phases, and both handshake sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_parameter_change_point_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_QUEUE_LIMIT  = 0;
    localparam int REG_POINTS_LIMIT = 1;
    localparam int N_ENTRIES        = 32;
    localparam int N_POINTS         = 16;
    localparam int PHASE_REQS       = 235;
    localparam int IDLE_LIMIT       = 3000;
    localparam int HOLD_LEN         = 300;

    typedef struct {
        pctab_pkg::t_in  req;
        bit              typed;
        pctab_pkg::t_out res;
    } t_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    pctab_pkg::t_in  i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    pctab_pkg::t_out o_out_data;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    parameter_change_point_table u_top (.*);

    always #5 i_clk = ~i_clk;

    // Model state of the table.
    logic [31:0]        tab_ids   [N_ENTRIES];
    logic [4:0]         tab_cnts  [N_ENTRIES];
    logic signed [31:0] tab_offs  [N_ENTRIES][N_POINTS];
    logic [63:0]        tab_vals  [N_ENTRIES][N_POINTS];
    int                 tab_used;
    int                 queue_lim;
    int                 points_lim;

    pctab_pkg::t_out pending_results[$];
    t_row            rows[$];
    int              fail_count = 0;
    int              tx_idle_pct = 0;
    int              rx_stall_pct = 0;
    int              rx_hold_cycles = 0;
    int              hold_starts = 0;
    int              hold_seen = 0;
    int              idle_cycles = 0;
    logic [31:0]     id_pool[40];

    function automatic pctab_pkg::t_out predict_result(pctab_pkg::t_in r);
        pctab_pkg::t_out o;
        int   q;
        int   p;
        int   cap;
        int   cnt;
        bit   ok;
        o = '0;
        case (r.command)
            pctab_pkg::CMD_CLEAR: tab_used = 0;
            pctab_pkg::CMD_ADD, pctab_pkg::CMD_SET: begin
                q = -1;
                for (int i = 0; i < tab_used; i++)
                    if (q < 0 && tab_ids[i] == r.param_id) q = i;
                if (q < 0 && tab_used < ((queue_lim < N_ENTRIES) ? queue_lim : N_ENTRIES)) begin
                    q = tab_used;
                    tab_ids[q] = r.param_id;
                    tab_cnts[q] = 5'd0;
                    tab_used++;
                end
                if (q < 0) begin
                    o.status = pctab_pkg::ST_FULL;
                end else begin
                    if (r.command == pctab_pkg::CMD_SET) begin
                        p = 0;
                        tab_cnts[q] = 5'd1;
                    end else begin
                        cap = (points_lim == 0) ? 1 : points_lim;
                        if (cap > N_POINTS) cap = N_POINTS;
                        if (int'(tab_cnts[q]) < cap) begin
                            p = int'(tab_cnts[q]);
                            tab_cnts[q] = 5'(p + 1);
                        end else begin
                            p = cap - 1;
                            tab_cnts[q] = 5'(cap);
                        end
                    end
                    tab_offs[q][p] = r.sample_offset;
                    tab_vals[q][p] = r.point_value;
                    o.status = pctab_pkg::ST_OK;
                    o.queue_index = 5'(q);
                    o.point_index = 4'(p);
                    o.found_id = tab_ids[q];
                    o.found_offset = r.sample_offset;
                    o.found_value = r.point_value;
                    o.point_count = tab_cnts[q];
                end
            end
            pctab_pkg::CMD_READ, pctab_pkg::CMD_READ_LAST: begin
                if (int'(r.entry_select) >= tab_used) begin
                    o.status = pctab_pkg::ST_RANGE;
                end else begin
                    cnt = int'(tab_cnts[r.entry_select]);
                    o.queue_index = r.entry_select;
                    o.found_id = tab_ids[r.entry_select];
                    o.point_count = 5'(cnt);
                    if (r.command == pctab_pkg::CMD_READ) begin
                        p = int'(r.point_select);
                        ok = p < cnt;
                    end else begin
                        ok = cnt != 0;
                        p = ok ? cnt - 1 : 0;
                    end
                    o.point_index = 4'(p);
                    if (ok && p < N_POINTS) begin
                        o.status = pctab_pkg::ST_OK;
                        o.found_offset = tab_offs[r.entry_select][p];
                        o.found_value = tab_vals[r.entry_select][p];
                    end else begin
                        o.status = pctab_pkg::ST_RANGE;
                    end
                end
            end
            default: o.status = pctab_pkg::ST_RANGE;
        endcase
        o.queues_in_use = 6'(tab_used);
        return o;
    endfunction

    function automatic pctab_pkg::t_in make_req(logic [2:0] cmd, logic [31:0] id,
                                                logic [31:0] off, logic [63:0] val,
                                                logic [4:0] esel, logic [3:0] psel_i);
        pctab_pkg::t_in r;
        r.command = cmd;
        r.param_id = id;
        r.sample_offset = off;
        r.point_value = val;
        r.entry_select = esel;
        r.point_select = psel_i;
        return r;
    endfunction

    function automatic pctab_pkg::t_out make_res(logic [1:0] st, logic [4:0] qi,
                                                 logic [3:0] pi, logic [31:0] id,
                                                 logic [31:0] off, logic [63:0] val,
                                                 logic [4:0] cnt, logic [5:0] used);
        pctab_pkg::t_out o;
        o.status = st;
        o.queue_index = qi;
        o.point_index = pi;
        o.found_id = id;
        o.found_offset = off;
        o.found_value = val;
        o.point_count = cnt;
        o.queues_in_use = used;
        return o;
    endfunction

    function automatic void add_row(pctab_pkg::t_in req, bit typed, pctab_pkg::t_out res);
        rows.insert(rows.size(), '{req, typed, res});
    endfunction

    function automatic pctab_pkg::t_in random_req();
        pctab_pkg::t_in r;
        int  w;
        int  hi;
        w = $urandom_range(0, 99);
        if (w < 38)      r.command = pctab_pkg::CMD_ADD;
        else if (w < 52) r.command = pctab_pkg::CMD_SET;
        else if (w < 75) r.command = pctab_pkg::CMD_READ;
        else if (w < 92) r.command = pctab_pkg::CMD_READ_LAST;
        else if (w < 95) r.command = pctab_pkg::CMD_CLEAR;
        else             r.command = 3'($urandom_range(5, 7));
        r.param_id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 39)];
        r.sample_offset = $urandom();
        r.point_value = {$urandom(), $urandom()};
        hi = (tab_used + 1 > 31) ? 31 : tab_used + 1;
        r.entry_select = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(0, hi));
        r.point_select = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic send_req(pctab_pkg::t_in r, bit typed, pctab_pkg::t_out res);
        pctab_pkg::t_out pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_result(r);
        pending_results.insert(pending_results.size(), typed ? res : pred);
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * idx);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_QUEUE_LIMIT) queue_lim = int'(val[5:0]);
        else points_lim = int'(val[4:0]);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pctab_pkg::t_out e;
        if (o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, o_out_data.status);
                check_field("queue_index", e.queue_index, o_out_data.queue_index);
                check_field("point_index", e.point_index, o_out_data.point_index);
                check_field("found_id", e.found_id, o_out_data.found_id);
                check_field("found_offset", e.found_offset, o_out_data.found_offset);
                check_field("found_value", e.found_value, o_out_data.found_value);
                check_field("point_count", e.point_count, o_out_data.point_count);
                check_field("queues_in_use", e.queues_in_use, o_out_data.queues_in_use);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_starts != hold_seen) begin
            hold_seen <= hold_starts;
            rx_hold_cycles <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial begin
        int    q_cfg[8];
        int    p_cfg[8];
        int    mode;
        q_cfg = '{32, 0, 1, 3, 63, 32, 8, 2};
        p_cfg = '{16, 1, 0, 2, 31, 1, 16, 5};
        tab_used = 0;
        queue_lim = 32;
        points_lim = 16;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 40; i++) id_pool[i] = $urandom();

        add_row(make_req(pctab_pkg::CMD_READ, 0, 0, 0, 0, 0), 1,
                make_res(pctab_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(pctab_pkg::CMD_READ_LAST, 0, 0, 0, 31, 15), 1,
                make_res(pctab_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(pctab_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h8000_0000, '1, 0, 0), 1,
                make_res(pctab_pkg::ST_OK, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, '1, 1, 1));
        add_row(make_req(pctab_pkg::CMD_ADD, 0, 32'h7FFF_FFFF, 0, 0, 0), 1,
                make_res(pctab_pkg::ST_OK, 1, 0, 0, 32'h7FFF_FFFF, 0, 1, 2));
        add_row(make_req(pctab_pkg::CMD_ADD, 32'hFFFF_FFFF, 0, 64'h1, 31, 15), 0, '0);
        add_row(make_req(pctab_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h1234, 64'h55AA, 0, 0), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ, 0, 0, 0, 0, 2), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ, 0, 0, 0, 0, 15), 0, '0);
        add_row(make_req(pctab_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hAA55, 0, 0),
                0, '0);
        add_row(make_req(pctab_pkg::CMD_READ_LAST, 0, 0, 0, 0, 0), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ, 0, 0, 0, 0, 1), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ_LAST, 0, 0, 0, 1, 0), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ, 0, 0, 0, 2, 0), 0, '0);
        add_row(make_req(3'd5, 1, 1, 1, 1, 1), 1,
                make_res(pctab_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 2));
        add_row(make_req(3'd7, '1, '1, '1, '1, '1), 1,
                make_res(pctab_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 2));
        add_row(make_req(pctab_pkg::CMD_CLEAR, '1, '1, '1, '1, '1), 1,
                make_res(pctab_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(pctab_pkg::CMD_READ_LAST, 0, 0, 0, 0, 0), 1,
                make_res(pctab_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(pctab_pkg::CMD_SET, 32'h5, 32'h8000_0000, 0, 0, 0), 0, '0);
        add_row(make_req(pctab_pkg::CMD_READ_LAST, 0, 0, 0, 0, 0), 0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_QUEUE_LIMIT, q_cfg[ph]);
            write_reg(REG_POINTS_LIMIT, p_cfg[ph]);
            mode = ph % 4;
            tx_idle_pct  = (mode == 1) ? 55 : (mode == 3) ? 18 : 0;
            rx_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 18 : 0;
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == 0 && n == 20) hold_starts = hold_starts + 1;
                if (ph == 4 && n == 100) drain();
                send_req(random_req(), 0, '0);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* parameter_change_point_table.f */
sv/pctab_pkg.sv
sv/pctab_cell.sv
sv/parameter_change_point_table.sv
sim/tb_parameter_change_point_table.sv
